### rtl/core/sha256_stream_hasher_defines.svh
// assertion macros for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// property must hold in the cycle after the trigger
`define SHA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

// property must hold in the same cycle as the trigger
`define SHA_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

### rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// constants, types and the rotate helper shared by the sha256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned ROUNDS = 64;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       write_byte;   // store one byte into the block buffer
		logic [5:0] byte_addr;
		logic [7:0] byte_val;
		logic       count_byte;   // advance the running byte total
		logic       load_sched;   // copy buffer into schedule, vars from hash
		logic       do_round;
		logic [5:0] round_idx;
		logic       add_hash;     // fold working vars into hash words
		logic       init_hash;    // restore initial values and clear total
		logic [2:0] len_sel;      // which length byte to supply
	} dp_cmd_t;

	typedef struct packed {
		logic [7:0]  len_byte;
		logic [31:0] hash_word;
	} dp_sts_t;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

### rtl/core/sha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// valid/ready channels for input items and digest words
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic             valid;
	logic             ready;
	sha_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
	logic              valid;
	logic              ready;
	sha_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/sha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/sha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// block buffer, rolling schedule, round logic, hash words and byte total
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"
module sha_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  sha_pkg::dp_cmd_t cmd,
	output sha_pkg::dp_sts_t sts,
	input  logic [2:0]       word_sel
);
	import sha_pkg::*;

	logic [7:0]  rd_byte;
	logic [31:0] sched_q [16];
	logic [31:0] var_q [8];
	logic [31:0] hash_q [8];
	logic [63:0] total_q;
	logic        rd_valid_q;
	logic [5:0]  rd_addr_q;
	logic [31:0] wr, w15, w2, s0, s1, t1, t2;
	logic [31:0] a, b, c, d, e, f, g, h;
	logic [63:0] bits;

	// buffer is read sequentially during load; cmd.byte_addr doubles as read address
	sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
		.clk  (clk),
		.we   (cmd.write_byte),
		.addr (cmd.byte_addr),
		.wdata(cmd.byte_val),
		.rdata(rd_byte)
	);

	always_comb begin
		a = var_q[0]; b = var_q[1]; c = var_q[2]; d = var_q[3];
		e = var_q[4]; f = var_q[5]; g = var_q[6]; h = var_q[7];
		w15 = sched_q[1];
		w2  = sched_q[14];
		s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
		s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
		// schedule shifts so that index 0 always holds w[r]
		wr = sched_q[0];
		t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
			+ ROUND_K[cmd.round_idx] + wr;
		t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		bits = total_q << 3;
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= cmd.load_sched;
		rd_addr_q  <= cmd.byte_addr;
		if (rd_valid_q) begin
			// shift byte into the schedule word selected by the address
			sched_q[rd_addr_q[5:2]] <= {sched_q[rd_addr_q[5:2]][23:0], rd_byte};
		end
		if (cmd.load_sched && cmd.byte_addr == 6'd0) begin
			for (int i = 0; i < 8; i++)
				var_q[i] <= hash_q[i];
		end
		if (cmd.do_round) begin
			for (int i = 0; i < 15; i++)
				sched_q[i] <= sched_q[i+1];
			sched_q[15] <= sched_q[0] + s0 + sched_q[9] + s1;
			var_q[7] <= g; var_q[6] <= f; var_q[5] <= e; var_q[4] <= d + t1;
			var_q[3] <= c; var_q[2] <= b; var_q[1] <= a; var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_q[i] <= HASH_IV[i];
			total_q <= '0;
		end else begin
			if (cmd.init_hash) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= HASH_IV[i];
				total_q <= '0;
			end else begin
				if (cmd.add_hash)
					for (int i = 0; i < 8; i++)
						hash_q[i] <= hash_q[i] + var_q[i];
				if (cmd.count_byte)
					total_q <= total_q + 64'd1;
			end
		end
	end

	always_comb begin
		sts.hash_word = hash_q[word_sel];
		sts.len_byte  = bits[8'(7 - cmd.len_sel) * 8 +: 8];
	end

	`SHA_ASSERT_NOW(a_no_round_during_load, clk, arst_n, cmd.do_round,
		!cmd.load_sched && !cmd.write_byte, "round overlaps buffer access")
	`SHA_ASSERT_NOW(a_no_add_during_round, clk, arst_n, cmd.add_hash,
		!cmd.do_round, "hash add during round")
	`SHA_ASSERT_NEXT(a_init_clears_total, clk, arst_n, cmd.init_hash,
		total_q == 64'd0, "byte total not cleared")
endmodule

### rtl/core/sha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: byte intake, padding, block load, rounds and digest output
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"
module sha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	sha_in_if.sink           in_ch,
	sha_out_if.source        out_ch,
	output sha_pkg::dp_cmd_t cmd,
	input  sha_pkg::dp_sts_t sts,
	output logic [2:0]       word_sel
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;  // write padding bytes
	localparam logic [2:0] ST_LOAD  = 3'd2;  // read buffer into schedule
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [6:0] fill_q;     // byte address counter, also load and pad index
	logic [5:0] round_q;
	logic       finish_q;   // padding in progress for this message
	logic       last_blk_q; // current block carries the length
	logic [2:0] word_q;
	logic [5:0] addr;
	logic       in_fire;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign word_sel = word_q;

	always_comb begin
		cmd = '0;
		addr = fill_q[5:0];
		cmd.byte_addr = addr;
		cmd.round_idx = round_q;
		cmd.len_sel = 3'(fill_q - 7'd56);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.write_byte = 1'b1;
					cmd.byte_val = in_ch.payload.kind ? PAD_BYTE : in_ch.payload.data_byte;
					cmd.count_byte = !in_ch.payload.kind;
				end
			end
			ST_PAD: begin
				cmd.write_byte = 1'b1;
				if (last_blk_q && fill_q >= 7'd56)
					cmd.byte_val = sts.len_byte;
				else
					cmd.byte_val = 8'h00;
			end
			ST_LOAD: cmd.load_sched = (fill_q < 7'd64);
			ST_ROUND: cmd.do_round = 1'b1;
			ST_ADD: cmd.add_hash = 1'b1;
			ST_OUT: cmd.init_hash = out_ch.ready && word_q == 3'd7;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			round_q <= '0;
			finish_q <= 1'b0;
			last_blk_q <= 1'b0;
			word_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_ch.payload.kind) begin
							finish_q <= 1'b1;
							last_blk_q <= (fill_q < 7'd56);
							fill_q <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
							state_q <= (fill_q == 7'd63) ? ST_LOAD : ST_PAD;
						end else if (fill_q == 7'd63) begin
							fill_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							fill_q <= fill_q + 7'd1;
						end
					end
				end
				ST_PAD: begin
					if (fill_q == 7'd63) begin
						fill_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
				end
				ST_LOAD: begin
					// the final load state, with fill at 64, drains the registered read
					if (fill_q == 7'd64) begin
						fill_q <= '0;
						round_q <= '0;
						state_q <= ST_ROUND;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(ROUNDS - 1))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!finish_q) begin
						state_q <= ST_IDLE;
					end else if (!last_blk_q) begin
						// length goes into a second, fully padded block
						last_blk_q <= 1'b1;
						state_q <= ST_PAD;
					end else begin
						word_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						word_q <= word_q + 3'd1;
						if (word_q == 3'd7) begin
							finish_q <= 1'b0;
							last_blk_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.payload.digest_word = sts.hash_word;
	assign out_ch.payload.word_index = word_q;
	assign out_ch.payload.last_word = (word_q == 3'd7);

	`SHA_ASSERT_NOW(a_fill_in_range, clk, arst_n, state_q != ST_LOAD,
		fill_q < 7'd64, "fill count out of range")
	`SHA_ASSERT_NEXT(a_rounds_then_add, clk, arst_n,
		state_q == ST_ROUND && round_q == 6'(ROUNDS - 1), state_q == ST_ADD,
		"round sequence did not end in add")
	`SHA_ASSERT_NOW(a_out_only_when_final, clk, arst_n, out_ch.valid,
		finish_q && last_blk_q, "digest shown before final block")
endmodule

### rtl/core/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial sha-256 with digest emitted as eight 32-bit words
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   kind, data_byte
// out_ch    out  digest_word, word_index, last_word
//
// a data byte is accepted while the sequencer is idle; the 64th byte of a block
// starts a compression: buffer load, rounds (one round per cycle) and hash add.
// finish pads byte by byte to the end of the block, compresses once or twice,
// then offers eight words, one per accepted transaction.
// reset returns the hash words to their initial values; no clearing pass.
// input is stalled whenever the sequencer is busy; output stalls hold the word.
module sha256_stream_hasher (
	input logic        clk,
	input logic        arst_n,
	sha_in_if.sink     in_ch,
	sha_out_if.source  out_ch
);
	import sha_pkg::*;

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [2:0] word_sel;

	sha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cmd     (cmd),
		.sts     (sts),
		.word_sel(word_sel)
	);

	sha_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.word_sel(word_sel)
	);
endmodule
